// ===== rtl/rpy_pkg.sv =====
// Shared types, constants and the arctangent table for the quaternion to RPY pipeline.
// Depends on nothing.
`timescale 1ns / 1ps
package rpy_pkg;

    localparam int QW        = 16;
    localparam int PW        = 32;
    localparam int MW        = 34;
    localparam int SW        = 32;
    localparam int VW        = 61;
    localparam int CW        = 31;
    localparam int ISQ_STEPS = 31;
    localparam int XW        = 37;
    localparam int ZW        = 25;
    localparam int AW        = 18;
    localparam int ROUND_SH  = 7;
    localparam int TAB_LEN   = 24;

    localparam logic signed [MW-1:0] ONE_Q30  = MW'(64'sd1073741824);
    localparam logic signed [SW-1:0] SAT_POS  = SW'(64'sd1073741824);
    localparam logic signed [SW-1:0] SAT_NEG  = -SW'(64'sd1073741824);
    localparam logic [VW-1:0]        ONE_Q60  = VW'(64'd1) << 60;
    localparam logic signed [ZW-1:0] PI_Q20   = ZW'(64'sd3294199);
    localparam logic signed [AW-1:0] ROLL_LIM  = AW'(64'sd25736);
    localparam logic signed [AW-1:0] PITCH_LIM = AW'(64'sd12868);

    typedef struct packed {
        logic signed [MW-1:0] r00;
        logic signed [MW-1:0] r10;
        logic signed [MW-1:0] r21;
        logic signed [MW-1:0] r22;
        logic signed [SW-1:0] s;
    } t_side;

    function automatic logic signed [ZW-1:0] atan_q20(input int idx);
        logic signed [ZW-1:0] v;
        case (idx)
            0:  v = ZW'(823550);
            1:  v = ZW'(486170);
            2:  v = ZW'(256879);
            3:  v = ZW'(130396);
            4:  v = ZW'(65451);
            5:  v = ZW'(32757);
            6:  v = ZW'(16383);
            7:  v = ZW'(8192);
            8:  v = ZW'(4096);
            9:  v = ZW'(2048);
            10: v = ZW'(1024);
            11: v = ZW'(512);
            12: v = ZW'(256);
            13: v = ZW'(128);
            14: v = ZW'(64);
            15: v = ZW'(32);
            16: v = ZW'(16);
            17: v = ZW'(8);
            18: v = ZW'(4);
            19: v = ZW'(2);
            20: v = ZW'(1);
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// ===== rtl/rpy_matrix.sv =====
// Three stages: pairwise products, rotation-matrix entries with the clipped asin
// argument, and the radicand for the cosine. Depends on rpy_pkg.
`timescale 1ns / 1ps
module rpy_matrix
    import rpy_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_valid,
    input  logic signed [QW-1:0] i_w,
    input  logic signed [QW-1:0] i_x,
    input  logic signed [QW-1:0] i_y,
    input  logic signed [QW-1:0] i_z,
    output logic                 o_valid,
    output t_side                o_side,
    output logic [VW-1:0]        o_v
);

    logic signed [PW-1:0] r_yy, r_zz, r_xy, r_wz, r_xz, r_wy, r_yz, r_wx, r_xx;
    logic                 r_v1, r_v2, r_v3;
    t_side                r_side2, r_side3, n_side2;
    logic [VW-1:0]        r_rad;
    logic signed [MW-1:0] n_r20;
    logic signed [MW-1:0] n_s;
    logic [CW-1:0]        n_mag;
    logic [2*CW-1:0]      n_sq;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_yy <= i_y * i_y;
            r_zz <= i_z * i_z;
            r_xy <= i_x * i_y;
            r_wz <= i_w * i_z;
            r_xz <= i_x * i_z;
            r_wy <= i_w * i_y;
            r_yz <= i_y * i_z;
            r_wx <= i_w * i_x;
            r_xx <= i_x * i_x;
        end
    end

    always_comb begin
        n_side2.r00 = ONE_Q30 - ((MW'(r_yy) + MW'(r_zz)) <<< 1);
        n_side2.r10 = (MW'(r_xy) + MW'(r_wz)) <<< 1;
        n_side2.r21 = (MW'(r_yz) + MW'(r_wx)) <<< 1;
        n_side2.r22 = ONE_Q30 - ((MW'(r_xx) + MW'(r_yy)) <<< 1);
        n_r20       = (MW'(r_xz) - MW'(r_wy)) <<< 1;
        n_s         = -n_r20;
        if (n_s > MW'(SAT_POS)) begin
            n_side2.s = SAT_POS;
        end else if (n_s < MW'(SAT_NEG)) begin
            n_side2.s = SAT_NEG;
        end else begin
            n_side2.s = SW'(n_s);
        end
    end

    always_comb begin
        n_mag = r_side2.s[SW-1] ? CW'(-r_side2.s) : CW'(r_side2.s);
        n_sq  = n_mag * n_mag;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_side2 <= n_side2;
            r_side3 <= r_side2;
            r_rad   <= ONE_Q60 - VW'(n_sq);
        end
    end

    assign o_valid = r_v3;
    assign o_side  = r_side3;
    assign o_v     = r_rad;

endmodule

// ===== rtl/rpy_isqrt.sv =====
// Integer square root, one result bit per stage, carrying the matrix entries alongside.
// Depends on rpy_pkg.
`timescale 1ns / 1ps
module rpy_isqrt
    import rpy_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_valid,
    input  t_side         i_side,
    input  logic [VW-1:0] i_v,
    output logic          o_valid,
    output t_side         o_side,
    output logic [CW-1:0] o_root
);

    logic [VW-1:0] r_v   [0:ISQ_STEPS-1];
    logic [VW-1:0] r_res [0:ISQ_STEPS-1];
    t_side         r_side[0:ISQ_STEPS-1];
    logic          r_vld [0:ISQ_STEPS-1];

    genvar j;
    generate
        for (j = 0; j < ISQ_STEPS; j++) begin : g_step
            localparam logic [VW-1:0] BIT = VW'(1) << (2 * (ISQ_STEPS - 1 - j));
            logic [VW-1:0] a_v, a_res;
            logic [VW:0]   a_trial;
            t_side         a_side;
            logic          a_vld;
            if (j == 0) begin : g_first
                assign a_v    = i_v;
                assign a_res  = '0;
                assign a_side = i_side;
                assign a_vld  = i_valid;
            end else begin : g_next
                assign a_v    = r_v[j-1];
                assign a_res  = r_res[j-1];
                assign a_side = r_side[j-1];
                assign a_vld  = r_vld[j-1];
            end
            assign a_trial = {1'b0, a_res} + {1'b0, BIT};

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_vld[j] <= 1'b0;
                end else if (i_en) begin
                    r_vld[j] <= a_vld;
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_side[j] <= a_side;
                    if ({1'b0, a_v} >= a_trial) begin
                        r_v[j]   <= a_v - a_trial[VW-1:0];
                        r_res[j] <= (a_res >> 1) + BIT;
                    end else begin
                        r_v[j]   <= a_v;
                        r_res[j] <= a_res >> 1;
                    end
                end
            end
        end
    endgenerate

    assign o_valid = r_vld[ISQ_STEPS-1];
    assign o_side  = r_side[ISQ_STEPS-1];
    assign o_root  = r_res[ISQ_STEPS-1][CW-1:0];

endmodule

// ===== rtl/rpy_cordic.sv =====
// Pipelined vectoring CORDIC giving atan2(y, x) rounded to Q3.13, unclamped.
// Depends on rpy_pkg.
`timescale 1ns / 1ps
module rpy_cordic
    import rpy_pkg::*;
#(
    parameter int CORDIC_STAGES = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_valid,
    input  logic signed [MW-1:0] i_y,
    input  logic signed [MW-1:0] i_x,
    output logic                 o_valid,
    output logic signed [AW-1:0] o_angle
);

    logic signed [XW-1:0] r_x  [0:CORDIC_STAGES];
    logic signed [XW-1:0] r_y  [0:CORDIC_STAGES];
    logic signed [ZW-1:0] r_z  [0:CORDIC_STAGES];
    logic                 r_zero[0:CORDIC_STAGES];
    logic                 r_vld[0:CORDIC_STAGES];
    logic signed [AW-1:0] r_ang;
    logic                 r_ang_vld;
    logic signed [XW-1:0] n_x, n_y;
    logic signed [ZW-1:0] n_round;

    assign n_x = XW'(i_x);
    assign n_y = XW'(i_y);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else if (i_en) begin
            r_vld[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_zero[0] <= (i_x == '0) && (i_y == '0);
            if (i_x < 0) begin
                r_x[0] <= -n_x;
                r_y[0] <= -n_y;
                r_z[0] <= (i_y >= 0) ? PI_Q20 : -PI_Q20;
            end else begin
                r_x[0] <= n_x;
                r_y[0] <= n_y;
                r_z[0] <= '0;
            end
        end
    end

    genvar i;
    generate
        for (i = 0; i < CORDIC_STAGES; i++) begin : g_iter
            localparam logic signed [ZW-1:0] ANG = atan_q20(i);
            logic signed [XW-1:0] a_xs, a_ys;
            assign a_xs = r_x[i] >>> i;
            assign a_ys = r_y[i] >>> i;

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_vld[i+1] <= 1'b0;
                end else if (i_en) begin
                    r_vld[i+1] <= r_vld[i];
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_zero[i+1] <= r_zero[i];
                    if (r_y[i] > 0) begin
                        r_x[i+1] <= r_x[i] + a_ys;
                        r_y[i+1] <= r_y[i] - a_xs;
                        r_z[i+1] <= r_z[i] + ANG;
                    end else begin
                        r_x[i+1] <= r_x[i] - a_ys;
                        r_y[i+1] <= r_y[i] + a_xs;
                        r_z[i+1] <= r_z[i] - ANG;
                    end
                end
            end
        end
    endgenerate

    assign n_round = (r_z[CORDIC_STAGES] + ZW'(64)) >>> ROUND_SH;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ang_vld <= 1'b0;
        end else if (i_en) begin
            r_ang_vld <= r_vld[CORDIC_STAGES];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ang <= r_zero[CORDIC_STAGES] ? '0 : AW'(n_round);
        end
    end

    assign o_valid = r_ang_vld;
    assign o_angle = r_ang;

endmodule

// ===== rtl/quaternion_to_euler_rpy.sv =====
// Top level: quaternion (Q1.15) to roll and yaw (Q3.13) and pitch (Q2.13) pipeline.
// Depends on rpy_pkg, rpy_matrix, rpy_isqrt, rpy_cordic.
//
//  channel | valid       | ready       | word
//  in      | i_in_valid  | o_in_ready  | i_quat_w, i_quat_x, i_quat_y, i_quat_z
//  out     | o_out_valid | i_out_ready | o_roll, o_pitch, o_yaw
//
// One word enters per cycle while the output is not held; the 31-stage square root
// sits in front of the CORDIC pipelines.
// Synchronous active-low reset clears every valid bit.
// A held output word freezes the whole pipeline; nothing is dropped or repeated.
`timescale 1ns / 1ps
module quaternion_to_euler_rpy
    import rpy_pkg::*;
#(
    parameter int CORDIC_STAGES = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic signed [15:0]   i_quat_w,
    input  logic signed [15:0]   i_quat_x,
    input  logic signed [15:0]   i_quat_y,
    input  logic signed [15:0]   i_quat_z,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic signed [15:0]   o_roll,
    output logic signed [14:0]   o_pitch,
    output logic signed [15:0]   o_yaw
);

    logic                 en;
    logic                 m_valid, q_valid, c_valid_r, c_valid_p, c_valid_y;
    t_side                m_side, q_side;
    logic [VW-1:0]        m_v;
    logic [CW-1:0]        q_root;
    logic signed [AW-1:0] a_roll, a_pitch, a_yaw;
    logic                 r_out_valid;
    logic signed [15:0]   r_roll, r_yaw;
    logic signed [14:0]   r_pitch;

    assign en         = !r_out_valid || i_out_ready;
    assign o_in_ready = en;

    rpy_matrix u_matrix (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_in_valid),
        .i_w     (i_quat_w),
        .i_x     (i_quat_x),
        .i_y     (i_quat_y),
        .i_z     (i_quat_z),
        .o_valid (m_valid),
        .o_side  (m_side),
        .o_v     (m_v)
    );

    rpy_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (m_valid),
        .i_side  (m_side),
        .i_v     (m_v),
        .o_valid (q_valid),
        .o_side  (q_side),
        .o_root  (q_root)
    );

    rpy_cordic #(.CORDIC_STAGES(CORDIC_STAGES)) u_roll (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (q_valid),
        .i_y     (q_side.r21),
        .i_x     (q_side.r22),
        .o_valid (c_valid_r),
        .o_angle (a_roll)
    );

    rpy_cordic #(.CORDIC_STAGES(CORDIC_STAGES)) u_pitch (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (q_valid),
        .i_y     (MW'(q_side.s)),
        .i_x     ($signed({{(MW-CW){1'b0}}, q_root})),
        .o_valid (c_valid_p),
        .o_angle (a_pitch)
    );

    rpy_cordic #(.CORDIC_STAGES(CORDIC_STAGES)) u_yaw (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (q_valid),
        .i_y     (q_side.r10),
        .i_x     (q_side.r00),
        .o_valid (c_valid_y),
        .o_angle (a_yaw)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= c_valid_r;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            if (a_roll > ROLL_LIM) begin
                r_roll <= 16'(ROLL_LIM);
            end else if (a_roll < -ROLL_LIM) begin
                r_roll <= 16'(-ROLL_LIM);
            end else begin
                r_roll <= 16'(a_roll);
            end
            if (a_pitch > PITCH_LIM) begin
                r_pitch <= 15'(PITCH_LIM);
            end else if (a_pitch < -PITCH_LIM) begin
                r_pitch <= 15'(-PITCH_LIM);
            end else begin
                r_pitch <= 15'(a_pitch);
            end
            if (a_yaw > ROLL_LIM) begin
                r_yaw <= 16'(ROLL_LIM);
            end else if (a_yaw < -ROLL_LIM) begin
                r_yaw <= 16'(-ROLL_LIM);
            end else begin
                r_yaw <= 16'(a_yaw);
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_roll      = r_roll;
    assign o_pitch     = r_pitch;
    assign o_yaw       = r_yaw;

`ifndef NO_ASSERTIONS
    a_lanes_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (c_valid_r == c_valid_p) && (c_valid_r == c_valid_y))
        else $error("angle lanes out of step");

    a_roll_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_roll <= 16'sd25736) && (o_roll >= -16'sd25736)
                     && (o_yaw <= 16'sd25736) && (o_yaw >= -16'sd25736))
        else $error("roll or yaw beyond pi");

    a_pitch_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_pitch <= 15'sd12868) && (o_pitch >= -15'sd12868))
        else $error("pitch beyond pi/2");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");
`endif

endmodule
